>>> sv/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain: shared definitions
// Constants, register indexes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package adsr_pkg;

	// Default widths of the position counters and of the audio samples.
	localparam int COUNT_BITS_DEF  = 24;
	localparam int SAMPLE_BITS_DEF = 24;

	// Q16 gain: 17 bits so that unity itself can be held.
	localparam int GAIN_BITS = 17;
	localparam int FRAC_BITS = 16;
	localparam logic [GAIN_BITS-1:0] UNITY = 17'h10000;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SUSTAIN = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NOTE    = 3'd4;

	// Which quotient the shared divider is producing.
	typedef enum logic [1:0] {
		DIV_ATTACK,
		DIV_DECAY,
		DIV_RELEASE
	} div_src_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASS,
		ST_PRODUCT,
		ST_DIV1,
		ST_DIV1_WAIT,
		ST_DIV2,
		ST_DIV2_WAIT,
		ST_SCALE,
		ST_APPLY,
		ST_DONE
	} adsr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     classify;
		logic     product;
		logic     div_start;
		logic     div_capture;
		div_src_t div_src;
		logic     gain_sus;
		logic     scale;
		logic     apply;
		logic     out_load;
	} adsr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bypass;
		logic attack_phase;
		logic decay_phase;
		logic rel_phase;
		logic div_done;
		logic out_free;
	} adsr_status_t;

endpackage

>>> sv/adsr_div.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain: shared divider
// Restoring division producing one quotient bit per cycle. The dividend is
// given as a high part below the divisor and a 16-bit low part, so the
// quotient always fits in 16 bits.
// ----------------------------------------------------------------------------
module adsr_div
	import adsr_pkg::*;
#(
	parameter int WIDTH = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WIDTH-1:0]     dividend_hi,
	input  logic [FRAC_BITS-1:0] dividend_lo,
	input  logic [WIDTH-1:0]     divisor,
	output logic [FRAC_BITS-1:0] quotient,
	output logic                 done
);

	localparam int CNT_BITS = $clog2(FRAC_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [WIDTH-1:0]     rem_q;
	logic [WIDTH-1:0]     div_q;
	logic [FRAC_BITS-1:0] shift_q;

	logic [WIDTH:0] trial;
	logic [WIDTH:0] diff;
	logic           fits;

	// One trial subtraction of the divisor from the shifted remainder.
	assign trial = {rem_q, shift_q[FRAC_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and the shift register that turns dividend bits into quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= dividend_hi;
			div_q   <= divisor;
			shift_q <= dividend_lo;
		end else if (busy_q) begin
			rem_q   <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			shift_q <= {shift_q[FRAC_BITS-2:0], fits};
		end
	end

	assign quotient = shift_q;
	assign done     = done_q;

endmodule

>>> sv/adsr_datapath.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain: datapath
// Configuration registers, note position, phase classification, the
// multipliers, the shared divider and the output register.
// ----------------------------------------------------------------------------
module adsr_datapath
	import adsr_pkg::*;
#(
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CFG_BITS    = (COUNT_BITS > GAIN_BITS) ? COUNT_BITS : GAIN_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_BITS-1:0]           cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          note_start,
	input  adsr_cmd_t                     cmd,
	output adsr_status_t                  status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [SAMPLE_BITS-1:0]        sample_out,
	output logic [GAIN_BITS-1:0]          gain_applied,
	output logic                          note_end
);

	// Configuration registers.
	logic [COUNT_BITS-1:0] attack_q;
	logic [COUNT_BITS-1:0] decay_q;
	logic [COUNT_BITS-1:0] release_q;
	logic [GAIN_BITS-1:0]  sustain_q;
	logic [COUNT_BITS-1:0] note_q;

	// Item state.
	logic [COUNT_BITS-1:0]         position_q;
	logic [COUNT_BITS-1:0]         n_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          att_q;
	logic                          dec_q;
	logic                          rel_q;
	logic [COUNT_BITS-1:0]         rs_q;
	logic [COUNT_BITS-1:0]         dec_diff_q;
	logic [COUNT_BITS-1:0]         rel_diff_q;
	logic [COUNT_BITS+GAIN_BITS-1:0] prod1_q;
	logic [GAIN_BITS-1:0]          g_q;
	logic [GAIN_BITS-1:0]          f_q;
	logic [SAMPLE_BITS-1:0]        y_q;
	logic                          last_q;

	// Output register.
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_y_q;
	logic [GAIN_BITS-1:0]   out_g_q;
	logic                   out_last_q;

	logic [GAIN_BITS-1:0]  sus_eff;
	logic [GAIN_BITS-1:0]  sus_comp;
	logic [COUNT_BITS-1:0] n_sel;
	logic [COUNT_BITS:0]   ad_sum;
	logic [COUNT_BITS:0]   nr_sum;
	logic [COUNT_BITS+GAIN_BITS-1:0] prod1;
	logic [2*GAIN_BITS-1:0] scale_prod;
	logic signed [SAMPLE_BITS+GAIN_BITS:0] apply_prod;

	logic                  div_start;
	logic [COUNT_BITS-1:0] div_hi;
	logic [FRAC_BITS-1:0]  div_lo;
	logic [COUNT_BITS-1:0] div_den;
	logic [FRAC_BITS-1:0]  div_quo;
	logic                  div_done;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= '0;
			release_q <= '0;
			sustain_q <= UNITY;
			note_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ATTACK:  attack_q  <= cfg_data[COUNT_BITS-1:0];
				CFG_DECAY:   decay_q   <= cfg_data[COUNT_BITS-1:0];
				CFG_RELEASE: release_q <= cfg_data[COUNT_BITS-1:0];
				CFG_SUSTAIN: sustain_q <= cfg_data[GAIN_BITS-1:0];
				CFG_NOTE:    note_q    <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sustain levels above unity count as unity.
	assign sus_eff  = (sustain_q > UNITY) ? UNITY : sustain_q;
	assign sus_comp = UNITY - sus_eff;

	// Index of this sample: restarts and stale positions begin at zero.
	assign n_sel = (note_start || position_q >= note_q) ? '0 : position_q;

	// Phase boundaries.
	assign ad_sum = {1'b0, attack_q} + {1'b0, decay_q};
	assign nr_sum = {1'b0, n_q} + {1'b0, release_q};

	// Products.
	assign prod1      = dec_diff_q * sus_comp;
	assign scale_prod = g_q * f_q;
	assign apply_prod = x_q * $signed({1'b0, g_q});

	// Position counter; it advances once per enveloped sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (cmd.classify) begin
			position_q <= (n_q == note_q - 1'b1) ? '0 : n_q + 1'b1;
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= sample_in;
			n_q <= n_sel;
			if (status.bypass) begin
				y_q    <= sample_in;
				g_q    <= UNITY;
				last_q <= 1'b0;
			end
		end
		if (cmd.classify) begin
			att_q      <= (attack_q != '0) && (n_q < attack_q);
			dec_q      <= (decay_q != '0) && ({1'b0, n_q} < ad_sum);
			rel_q      <= (release_q != '0) &&
			              ((release_q >= note_q) || (nr_sum >= {1'b0, note_q}));
			rs_q       <= (release_q < note_q) ? note_q - release_q : '0;
			dec_diff_q <= n_q - attack_q;
			last_q     <= (n_q == note_q - 1'b1);
		end
		if (cmd.product) begin
			prod1_q    <= prod1;
			rel_diff_q <= n_q - rs_q;
		end
		if (cmd.gain_sus) begin
			g_q <= sus_eff;
		end
		if (cmd.div_capture) begin
			case (cmd.div_src)
				DIV_ATTACK:  g_q <= {1'b0, div_quo};
				DIV_DECAY:   g_q <= UNITY - {1'b0, div_quo};
				DIV_RELEASE: f_q <= UNITY - {1'b0, div_quo};
				default: ;
			endcase
		end
		if (cmd.scale) begin
			g_q <= scale_prod[FRAC_BITS+GAIN_BITS-1:FRAC_BITS];
		end
		if (cmd.apply) begin
			y_q <= apply_prod[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];
		end
	end

	// Divider operands for the three ramps.
	always_comb begin
		div_hi  = n_q;
		div_lo  = '0;
		div_den = attack_q;
		case (cmd.div_src)
			DIV_ATTACK: begin
				div_hi  = n_q;
				div_den = attack_q;
			end
			DIV_DECAY: begin
				div_hi  = prod1_q[COUNT_BITS+FRAC_BITS-1:FRAC_BITS];
				div_lo  = prod1_q[FRAC_BITS-1:0];
				div_den = decay_q;
			end
			DIV_RELEASE: begin
				div_hi  = rel_diff_q;
				div_den = release_q;
			end
			default: ;
		endcase
	end

	assign div_start = cmd.div_start;

	adsr_div #(
		.WIDTH(COUNT_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend_hi(div_hi),
		.dividend_lo(div_lo),
		.divisor    (div_den),
		.quotient   (div_quo),
		.done       (div_done)
	);

	// Output register, parting the result side from the work in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_y_q    <= y_q;
			out_g_q    <= g_q;
			out_last_q <= last_q;
		end
	end

	// Status towards the controller.
	assign status.bypass       = (note_q == '0);
	assign status.attack_phase = att_q;
	assign status.decay_phase  = dec_q;
	assign status.rel_phase    = rel_q;
	assign status.div_done     = div_done;
	assign status.out_free     = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign sample_out   = out_y_q;
	assign gain_applied = out_g_q;
	assign note_end     = out_last_q;

endmodule

>>> sv/adsr_ctrl.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain: controller
// Sequences one sample through classification, the ramp divisions, the
// release scaling and the output register.
// ----------------------------------------------------------------------------
module adsr_ctrl
	import adsr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  adsr_status_t status,
	output adsr_cmd_t    cmd
);

	adsr_state_t state_q;
	adsr_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_src = status.attack_phase ? DIV_ATTACK : DIV_DECAY;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.bypass ? ST_DONE : ST_CLASS;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				state_d      = ST_PRODUCT;
			end
			ST_PRODUCT: begin
				cmd.product = 1'b1;
				if (status.attack_phase || status.decay_phase) begin
					state_d = ST_DIV1;
				end else begin
					cmd.gain_sus = 1'b1;
					state_d      = status.rel_phase ? ST_DIV2 : ST_APPLY;
				end
			end
			ST_DIV1: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV1_WAIT;
			end
			ST_DIV1_WAIT: begin
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = status.rel_phase ? ST_DIV2 : ST_APPLY;
				end
			end
			ST_DIV2: begin
				cmd.div_src   = DIV_RELEASE;
				cmd.div_start = 1'b1;
				state_d       = ST_DIV2_WAIT;
			end
			ST_DIV2_WAIT: begin
				cmd.div_src = DIV_RELEASE;
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/adsr_envelope_gain.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain: top level
// Multiplies each audio sample by a linear attack, decay, sustain and release
// gain taken from its position within a note of configured length.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  tdata: sample_in; tuser: note_start
//   m_*       out        m_tvalid / m_tready  tdata: sample_out, gain_applied;
//                                             tlast: note_end
//   cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample is in work at a time. A pass-through sample (note length zero)
// goes from its transaction straight to the done state and reaches the output
// register once the output is free; an enveloped sample first passes
// through classification, a product, up to two ramp divisions on the shared
// bit-serial divider, the release scaling where needed and the apply step.
// The next sample is accepted in the cycle after the result has been loaded.
// A new sample is accepted while the previous result still waits in the output
// register; a stalled output holds the finished sample before the output
// register. Reset is asynchronous and restores the register defaults and
// position zero. Configuration transactions are always accepted.
// ----------------------------------------------------------------------------
module adsr_envelope_gain
	import adsr_pkg::*;
#(
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int IN_BITS     = ((SAMPLE_BITS + 7) / 8) * 8,
	parameter int OUT_BITS    = ((SAMPLE_BITS + GAIN_BITS + 7) / 8) * 8,
	parameter int CFG_BITS    = (COUNT_BITS > GAIN_BITS) ? COUNT_BITS : GAIN_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Input samples.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_BITS-1:0]        s_tdata,   // sample_in
	input  logic [0:0]                s_tuser,   // note_start
	// Results.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_BITS-1:0]       m_tdata,   // sample_out, gain_applied
	output logic                      m_tlast,   // note_end
	// Configuration writes.
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data
);

	adsr_cmd_t              cmd;
	adsr_status_t           status;
	logic [SAMPLE_BITS-1:0] sample_out;
	logic [GAIN_BITS-1:0]   gain_applied;

	// Configuration is taken in every cycle.
	assign cfg_ready = 1'b1;

	adsr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	adsr_datapath #(
		.COUNT_BITS (COUNT_BITS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CFG_BITS   (CFG_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_in   ($signed(s_tdata[SAMPLE_BITS-1:0])),
		.note_start  (s_tuser[0]),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.sample_out  (sample_out),
		.gain_applied(gain_applied),
		.note_end    (m_tlast)
	);

	// Result packing, sample in the lowest bits.
	assign m_tdata = OUT_BITS'({gain_applied, sample_out});

endmodule
